// ===== hdl/bfs_pkg.sv =====
// bfs_pkg: shared types and constants of the bilinear frame scaler
// no dependencies; every other file refers to it by scoped names
package bfs_pkg;

	localparam int ADDR_IN_W = 17;
	localparam int PIX_W     = 24;
	localparam int CHAN_W    = 8;
	localparam int NUM_CHAN  = 3;
	localparam int COORD_W   = 11;
	localparam int WIDTH_W   = 12;
	localparam int STEP_W    = 24;
	localparam int PROD_W    = COORD_W + STEP_W;
	localparam int POS_W     = PROD_W + 1;

	localparam int QDEPTH    = 8;
	localparam int Q_AW      = 3;
	localparam int Q_CW      = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = 2;
	localparam int OUT_CW    = 3;

	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	localparam logic [WIDTH_W-1:0] RST_SRC_WIDTH = 12'd400;
	localparam logic [STEP_W-1:0]  RST_STEP      = 24'd65536;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_SRC_WIDTH = 2'd0,
		REG_STEP_X    = 2'd1,
		REG_STEP_Y    = 2'd2
	} reg_idx_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} back_state_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] src_width;
		logic [STEP_W-1:0]  step_x;
		logic [STEP_W-1:0]  step_y;
	} cfg_t;

endpackage

// ===== hdl/bfs_in_if.sv =====
// bfs_in_if: request channel carrying pixel writes and output pixel reads
// depends on bfs_pkg for field widths
interface bfs_in_if;
	logic                           valid;
	logic                           ready;
	logic [0:0]                     op;
	logic [bfs_pkg::ADDR_IN_W-1:0]  addr;
	logic [bfs_pkg::PIX_W-1:0]      pixel;
	logic [bfs_pkg::COORD_W-1:0]    out_x;
	logic [bfs_pkg::COORD_W-1:0]    out_y;

	modport source (output valid, op, addr, pixel, out_x, out_y, input ready);
	modport sink (input valid, op, addr, pixel, out_x, out_y, output ready);
endinterface

// ===== hdl/bfs_out_if.sv =====
// bfs_out_if: result channel carrying interpolated colors
// depends on bfs_pkg for field widths
interface bfs_out_if;
	logic                      valid;
	logic                      ready;
	logic [bfs_pkg::PIX_W-1:0] color;

	modport source (output valid, color, input ready);
	modport sink (input valid, color, output ready);
endinterface

// ===== hdl/bilinear_frame_scaler.sv =====
// bilinear_frame_scaler: top level joining registers, front, command queue and back end
// write item: one frame store write; read item: four frame store reads, one per cycle,
// so a stream of reads is bound by the single frame store port
// arst_n clears control state, then the whole frame store is cleared with req.ready low
// depends on bfs_pkg, bfs_in_if, bfs_out_if, bfs_cfg, bfs_front, bfs_cmd_queue, bfs_back
module bilinear_frame_scaler #(
	parameter int FRAME_PIXELS = 131072,
	parameter int FRAC_BITS    = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bfs_in_if.sink                      req,
	bfs_out_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bfs_pkg::APB_AW-1:0]  paddr,
	input  logic [bfs_pkg::APB_DW-1:0]  pwdata,
	output logic [bfs_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	localparam int ADDR_W = $clog2(FRAME_PIXELS);
	localparam int CMD_W  = 1 + ADDR_W + bfs_pkg::PIX_W + 2 * FRAC_BITS;
	localparam logic [bfs_pkg::Q_CW-1:0] QFULL = bfs_pkg::Q_CW'(bfs_pkg::QDEPTH);

	bfs_pkg::cfg_t               cfg;
	logic                        clear_done;
	logic                        q_push;
	logic [CMD_W-1:0]            q_push_data;
	logic                        q_pop;
	logic                        q_head_valid;
	logic [CMD_W-1:0]            q_head_data;
	logic [bfs_pkg::Q_CW-1:0]    q_count;

	bfs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bfs_front #(
		.FRAME_PIXELS (FRAME_PIXELS),
		.FRAC_BITS    (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.clear_done (clear_done),
		.req        (req),
		.q_count    (q_count),
		.push       (q_push),
		.push_data  (q_push_data)
	);

	bfs_cmd_queue #(
		.WIDTH (CMD_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head_data),
		.count      (q_count)
	);

	bfs_back #(
		.FRAME_PIXELS (FRAME_PIXELS),
		.FRAC_BITS    (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_width  (cfg.src_width),
		.head_valid (q_head_valid),
		.head_data  (q_head_data),
		.pop        (q_pop),
		.clear_done (clear_done),
		.rsp        (rsp)
	);

	a_clear_stays_done: assert property (@(posedge clk) disable iff (!arst_n)
		clear_done |=> clear_done)
		else $error("store clear flag dropped after completion");

	a_no_item_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> clear_done)
		else $error("item accepted while frame store clears");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |-> (q_count < QFULL))
		else $error("command queue overflow");

	a_no_result_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> clear_done)
		else $error("result offered before frame store clear finished");

endmodule

// ===== hdl/bfs_cfg.sv =====
// bfs_cfg: apb register file for source width and the two step registers
// depends on bfs_pkg
module bfs_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bfs_pkg::APB_AW-1:0]  paddr,
	input  logic [bfs_pkg::APB_DW-1:0]  pwdata,
	output logic [bfs_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output bfs_pkg::cfg_t               cfg
);

	bfs_pkg::cfg_t cfg_q;
	logic          wr;
	logic [1:0]    idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[bfs_pkg::APB_AW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width <= bfs_pkg::RST_SRC_WIDTH;
			cfg_q.step_x    <= bfs_pkg::RST_STEP;
			cfg_q.step_y    <= bfs_pkg::RST_STEP;
		end else if (wr) begin
			case (idx)
				bfs_pkg::REG_SRC_WIDTH: cfg_q.src_width <= pwdata[bfs_pkg::WIDTH_W-1:0];
				bfs_pkg::REG_STEP_X:    cfg_q.step_x    <= pwdata[bfs_pkg::STEP_W-1:0];
				bfs_pkg::REG_STEP_Y:    cfg_q.step_y    <= pwdata[bfs_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bfs_pkg::REG_SRC_WIDTH: prdata = bfs_pkg::APB_DW'(cfg_q.src_width);
			bfs_pkg::REG_STEP_X:    prdata = bfs_pkg::APB_DW'(cfg_q.step_x);
			bfs_pkg::REG_STEP_Y:    prdata = bfs_pkg::APB_DW'(cfg_q.step_y);
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== hdl/bfs_front.sv =====
// bfs_front: accepts request items and turns read coordinates into a base address and fractions
// depends on bfs_pkg and bfs_in_if; feeds bfs_cmd_queue
module bfs_front #(
	parameter int FRAME_PIXELS = 131072,
	parameter int FRAC_BITS    = 16,
	localparam int ADDR_W      = $clog2(FRAME_PIXELS),
	localparam int CMD_W       = 1 + ADDR_W + bfs_pkg::PIX_W + 2 * FRAC_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bfs_pkg::cfg_t              cfg,
	input  logic                       clear_done,
	bfs_in_if.sink                     req,
	input  logic [bfs_pkg::Q_CW-1:0]   q_count,
	output logic                       push,
	output logic [CMD_W-1:0]           push_data
);

	localparam int PW   = bfs_pkg::POS_W;
	localparam int PRW  = bfs_pkg::PROD_W;
	localparam int RP_W = ADDR_W + bfs_pkg::WIDTH_W;
	localparam int LW   = bfs_pkg::Q_CW + 1;
	localparam logic [PW-1:0] ONE_POS = PW'(1) << FRAC_BITS;

	// stage 1: registered request
	logic                          valid_s1;
	bfs_pkg::op_t                  op_s1;
	logic [ADDR_W-1:0]             addr_s1;
	logic [bfs_pkg::PIX_W-1:0]     pixel_s1;
	logic [bfs_pkg::COORD_W-1:0]   x_s1;
	logic [bfs_pkg::COORD_W-1:0]   y_s1;

	// stage 2: sample position
	logic                          valid_s2;
	bfs_pkg::op_t                  op_s2;
	logic [ADDR_W-1:0]             addr_s2;
	logic [bfs_pkg::PIX_W-1:0]     pixel_s2;
	logic [PW-1:0]                 pos_x_s2;
	logic [PW-1:0]                 pos_y_s2;

	// stage 3: column, row offset and fractions
	logic                          valid_s3;
	bfs_pkg::op_t                  op_s3;
	logic [ADDR_W-1:0]             addr_s3;
	logic [bfs_pkg::PIX_W-1:0]     pixel_s3;
	logic [ADDR_W-1:0]             ix_s3;
	logic [ADDR_W-1:0]             row_s3;
	logic [FRAC_BITS-1:0]          fx_s3;
	logic [FRAC_BITS-1:0]          fy_s3;

	logic                          accept;
	logic [LW-1:0]                 level;
	logic [PRW-1:0]                prod_x;
	logic [PRW-1:0]                prod_y;
	logic [PW-1:0]                 stx;
	logic [PW-1:0]                 sty;
	logic [PW-1:0]                 start_x;
	logic [PW-1:0]                 start_y;
	logic [PW-1:0]                 ixf;
	logic [PW-1:0]                 iyf;
	logic [ADDR_W-1:0]             iy;
	logic [RP_W-1:0]               rowp;
	logic [ADDR_W-1:0]             cmd_addr;

	// queue slots already spoken for by items still in the stages
	assign level = LW'(q_count) + LW'(valid_s1) + LW'(valid_s2) + LW'(valid_s3);
	assign req.ready = clear_done && (level < LW'(bfs_pkg::QDEPTH));
	assign accept = req.valid && req.ready;

	assign prod_x  = PRW'(x_s1) * PRW'(cfg.step_x);
	assign prod_y  = PRW'(y_s1) * PRW'(cfg.step_y);
	assign stx     = PW'(cfg.step_x);
	assign sty     = PW'(cfg.step_y);
	assign start_x = (stx >= ONE_POS) ? (stx & (ONE_POS - PW'(1))) : stx;
	assign start_y = (sty >= ONE_POS) ? (sty & (ONE_POS - PW'(1))) : sty;

	assign ixf  = pos_x_s2 >> FRAC_BITS;
	assign iyf  = pos_y_s2 >> FRAC_BITS;
	assign iy   = iyf[ADDR_W-1:0];
	assign rowp = RP_W'(iy) * RP_W'(cfg.src_width);

	assign cmd_addr  = (op_s3 == bfs_pkg::OP_WRITE) ? addr_s3 : (row_s3 + ix_s3);
	assign push      = valid_s3;
	assign push_data = {op_s3, cmd_addr, pixel_s3, fx_s3, fy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= bfs_pkg::op_t'(req.op);
		addr_s1  <= ADDR_W'(req.addr);
		pixel_s1 <= req.pixel;
		x_s1     <= req.out_x;
		y_s1     <= req.out_y;

		op_s2    <= op_s1;
		addr_s2  <= addr_s1;
		pixel_s2 <= pixel_s1;
		pos_x_s2 <= start_x + PW'(prod_x);
		pos_y_s2 <= start_y + PW'(prod_y);

		op_s3    <= op_s2;
		addr_s3  <= addr_s2;
		pixel_s3 <= pixel_s2;
		ix_s3    <= ixf[ADDR_W-1:0];
		row_s3   <= rowp[ADDR_W-1:0];
		fx_s3    <= pos_x_s2[FRAC_BITS-1:0];
		fy_s3    <= pos_y_s2[FRAC_BITS-1:0];
	end

endmodule

// ===== hdl/bfs_cmd_queue.sv =====
// bfs_cmd_queue: short command queue between the front and the back end
// depends on bfs_pkg for depth and count width
module bfs_cmd_queue #(
	parameter int WIDTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [WIDTH-1:0]          push_data,
	input  logic                      pop,
	output logic                      head_valid,
	output logic [WIDTH-1:0]          head_data,
	output logic [bfs_pkg::Q_CW-1:0]  count
);

	logic [WIDTH-1:0]           q_q [bfs_pkg::QDEPTH];
	logic [bfs_pkg::Q_AW-1:0]   wr_q;
	logic [bfs_pkg::Q_AW-1:0]   rd_q;
	logic [bfs_pkg::Q_CW-1:0]   count_q;

	assign head_valid = (count_q != '0);
	assign head_data  = q_q[rd_q];
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + bfs_pkg::Q_CW'(push) - bfs_pkg::Q_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= push_data;
	end

endmodule

// ===== hdl/bfs_back.sv =====
// bfs_back: frame store, neighbour read sequencer, blend accumulator and result buffer
// depends on bfs_pkg and bfs_out_if; takes commands from bfs_cmd_queue
module bfs_back #(
	parameter int FRAME_PIXELS = 131072,
	parameter int FRAC_BITS    = 16,
	localparam int ADDR_W      = $clog2(FRAME_PIXELS),
	localparam int CMD_W       = 1 + ADDR_W + bfs_pkg::PIX_W + 2 * FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [bfs_pkg::WIDTH_W-1:0]   src_width,
	input  logic                          head_valid,
	input  logic [CMD_W-1:0]              head_data,
	output logic                          pop,
	output logic                          clear_done,
	bfs_out_if.source                     rsp
);

	localparam int F     = FRAC_BITS;
	localparam int FW1   = F + 1;
	localparam int WT_W  = 2 * F + 1;
	localparam int WP_W  = 2 * F + 2;
	localparam int ACC_W = 2 * F + 8;
	localparam int MP_W  = WT_W + bfs_pkg::CHAN_W;
	localparam int PXW   = bfs_pkg::PIX_W;
	localparam int CW    = bfs_pkg::CHAN_W;
	localparam int NC    = bfs_pkg::NUM_CHAN;
	localparam int OCW   = bfs_pkg::OUT_CW;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_PIXELS - 1);
	localparam logic [FW1-1:0]    ONE_F     = FW1'(1) << F;
	localparam logic [ACC_W-1:0]  HALF      = (ACC_W'(1) << (2 * F - 1)) - ACC_W'(1);
	localparam logic [1:0]        LAST_TERM = 2'd3;

	bfs_pkg::op_t          h_op;
	logic [ADDR_W-1:0]     h_addr;
	logic [PXW-1:0]        h_pixel;
	logic [F-1:0]          h_fx;
	logic [F-1:0]          h_fy;

	bfs_pkg::back_state_t  state_q;
	bfs_pkg::back_state_t  state_d;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic [1:0]            phase_q;
	logic [OCW-1:0]        used_q;

	logic                  mem_we;
	logic                  mem_re;
	logic [ADDR_W-1:0]     mem_addr;
	logic [PXW-1:0]        mem_wdata;
	logic                  start;
	logic [ADDR_W-1:0]     off;

	logic [FW1-1:0]        gx;
	logic [FW1-1:0]        gy;
	logic [FW1-1:0]        wx;
	logic [FW1-1:0]        wy;
	logic [WP_W-1:0]       wfull;

	logic [PXW-1:0]        mem [FRAME_PIXELS];

	logic                  valid_s1;
	logic                  first_s1;
	logic                  last_s1;
	logic [WT_W-1:0]       weight_s1;
	logic [PXW-1:0]        rdata_s1;

	logic                  valid_s2;
	logic                  first_s2;
	logic                  last_s2;
	logic [ACC_W-1:0]      prod_s2 [NC];

	logic [MP_W-1:0]       mp [NC];
	logic [ACC_W-1:0]      sum [NC];
	logic [ACC_W-1:0]      acc_q [NC];
	logic [PXW-1:0]        color;
	logic                  out_push;
	logic                  out_pop;

	logic [PXW-1:0]                ofifo_q [bfs_pkg::OUT_DEPTH];
	logic [bfs_pkg::OUT_AW-1:0]    owr_q;
	logic [bfs_pkg::OUT_AW-1:0]    ord_q;
	logic [OCW-1:0]                ocnt_q;

	assign h_op    = bfs_pkg::op_t'(head_data[CMD_W-1]);
	assign h_addr  = head_data[CMD_W-2 -: ADDR_W];
	assign h_pixel = head_data[2*F+PXW-1 -: PXW];
	assign h_fx    = head_data[2*F-1 -: F];
	assign h_fy    = head_data[F-1:0];

	assign clear_done = (state_q == bfs_pkg::ST_RUN);

	// terms in order: base, right, lower, lower right
	assign off = (phase_q[1] ? ADDR_W'(src_width) : '0) + ADDR_W'(phase_q[0]);

	assign gx    = ONE_F - {1'b0, h_fx};
	assign gy    = ONE_F - {1'b0, h_fy};
	assign wx    = phase_q[0] ? {1'b0, h_fx} : gx;
	assign wy    = phase_q[1] ? {1'b0, h_fy} : gy;
	assign wfull = WP_W'(wx) * WP_W'(wy);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bfs_pkg::ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) state_d = bfs_pkg::ST_RUN;
			end
			bfs_pkg::ST_RUN: state_d = bfs_pkg::ST_RUN;
			default: state_d = bfs_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = h_addr;
		mem_wdata = h_pixel;
		pop       = 1'b0;
		start     = 1'b0;
		case (state_q)
			bfs_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_addr_q;
				mem_wdata = '0;
			end
			bfs_pkg::ST_RUN: begin
				if (head_valid) begin
					if (h_op == bfs_pkg::OP_WRITE) begin
						mem_we = 1'b1;
						pop    = 1'b1;
					end else if (phase_q != 2'd0 || used_q < OCW'(bfs_pkg::OUT_DEPTH)) begin
						mem_re   = 1'b1;
						mem_addr = h_addr + off;
						pop      = (phase_q == LAST_TERM);
						start    = (phase_q == 2'd0);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bfs_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			phase_q    <= '0;
			used_q     <= '0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bfs_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
			if (mem_re) phase_q <= phase_q + 1'b1;
			used_q   <= used_q + OCW'(start) - OCW'(out_pop);
			valid_s1 <= mem_re;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rdata_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		first_s1  <= (phase_q == 2'd0);
		last_s1   <= (phase_q == LAST_TERM);
		weight_s1 <= wfull[WT_W-1:0];
		first_s2  <= first_s1;
		last_s2   <= last_s1;
		for (int k = 0; k < NC; k++) prod_s2[k] <= mp[k][ACC_W-1:0];
	end

	always_comb begin
		for (int k = 0; k < NC; k++) begin
			mp[k]  = MP_W'(rdata_s1[k*CW +: CW]) * MP_W'(weight_s1);
			sum[k] = (first_s2 ? HALF : acc_q[k]) + prod_s2[k];
			color[k*CW +: CW] = sum[k][2*F +: CW];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && !last_s2) begin
			for (int k = 0; k < NC; k++) acc_q[k] <= sum[k];
		end
	end

	// result buffer, space reserved when an item starts its reads
	assign out_push  = valid_s2 && last_s2;
	assign out_pop   = rsp.valid && rsp.ready;
	assign rsp.valid = (ocnt_q != '0);
	assign rsp.color = ofifo_q[ord_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (out_push) owr_q <= owr_q + 1'b1;
			if (out_pop) ord_q <= ord_q + 1'b1;
			ocnt_q <= ocnt_q + OCW'(out_push) - OCW'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (out_push) ofifo_q[owr_q] <= color;
	end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for bilinear_frame_scaler; loads source pixels, programs
// scale registers over apb and checks every interpolated color against an in-bench model
// depends on bfs_pkg, bfs_in_if, bfs_out_if and the bilinear_frame_scaler rtl
`timescale 1ns / 1ps

module tb_top;

	localparam int STORE_DEPTH = 131072;
	localparam int FRAC        = 16;
	localparam int SETTLE      = 40;
	localparam int STALL_LIMIT = 400000;
	localparam int PHASE_ITEMS = 88;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		bfs_pkg::op_t                  op;
		logic [bfs_pkg::ADDR_IN_W-1:0] addr;
		logic [bfs_pkg::PIX_W-1:0]     pixel;
		logic [bfs_pkg::COORD_W-1:0]   out_x;
		logic [bfs_pkg::COORD_W-1:0]   out_y;
	} scaler_req_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [bfs_pkg::APB_AW-1:0] paddr;
	logic [bfs_pkg::APB_DW-1:0] pwdata, prdata;

	bfs_in_if  req_if();
	bfs_out_if rsp_if();

	bilinear_frame_scaler #(
		.FRAME_PIXELS(STORE_DEPTH),
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	bit [bfs_pkg::PIX_W-1:0]     pixel_mem [0:STORE_DEPTH-1];
	logic [bfs_pkg::WIDTH_W-1:0] cur_width  = bfs_pkg::RST_SRC_WIDTH;
	logic [bfs_pkg::STEP_W-1:0]  cur_step_x = bfs_pkg::RST_STEP;
	logic [bfs_pkg::STEP_W-1:0]  cur_step_y = bfs_pkg::RST_STEP;

	scaler_req_t                pending_items[$];
	scaler_req_t                cur_req;
	logic [bfs_pkg::PIX_W-1:0]  expected_colors[$];
	logic [bfs_pkg::PIX_W-1:0]  want_color;
	int unsigned       send_gap_pct = 0;
	int unsigned       stall_pct    = 0;
	int                err_count    = 0;
	int                n_writes     = 0;
	int                n_reads      = 0;
	int                n_checked    = 0;
	int                n_settings   = 1;

	function automatic logic [bfs_pkg::POS_W-1:0] sample_pos(
			logic [bfs_pkg::STEP_W-1:0] step, logic [bfs_pkg::COORD_W-1:0] coord);
		logic [bfs_pkg::POS_W-1:0] start;
		start = (step >= 24'h010000) ? bfs_pkg::POS_W'(step[FRAC-1:0])
			: bfs_pkg::POS_W'(step);
		return start + bfs_pkg::POS_W'(coord) * bfs_pkg::POS_W'(step);
	endfunction

	function automatic logic [bfs_pkg::ADDR_IN_W-1:0] cell_addr(
			logic [bfs_pkg::POS_W-1:0] px, logic [bfs_pkg::POS_W-1:0] py);
		return py[FRAC+bfs_pkg::ADDR_IN_W-1:FRAC] * bfs_pkg::ADDR_IN_W'(cur_width)
			+ px[FRAC+bfs_pkg::ADDR_IN_W-1:FRAC];
	endfunction

	function automatic logic [7:0] mix2(logic [7:0] a, logic [7:0] n, logic [FRAC-1:0] f);
		logic [47:0] s;
		s = 48'(a) * (48'h10000 - 48'(f)) + 48'(n) * 48'(f) + 48'h7FFF;
		return s[FRAC+7:FRAC];
	endfunction

	function automatic logic [7:0] mix4(logic [7:0] a, logic [7:0] b, logic [7:0] c,
			logic [7:0] d, logic [FRAC-1:0] fx, logic [FRAC-1:0] fy);
		logic [47:0] gx, gy, s;
		gx = 48'h10000 - 48'(fx);
		gy = 48'h10000 - 48'(fy);
		s = 48'(a) * gx * gy + 48'(b) * 48'(fx) * gy + 48'(c) * gx * 48'(fy)
			+ 48'(d) * 48'(fx) * 48'(fy) + 48'h7FFFFFFF;
		return s[2*FRAC+7:2*FRAC];
	endfunction

	task automatic apply_item(input scaler_req_t it);
		logic [bfs_pkg::POS_W-1:0]     px, py;
		logic [FRAC-1:0]               fx, fy;
		logic [bfs_pkg::ADDR_IN_W-1:0] b, a01, a10, a11;
		logic [bfs_pkg::PIX_W-1:0]     p00, p01, p10, p11, nb, c;
		int k;
		if (it.op == bfs_pkg::OP_WRITE) begin
			pixel_mem[it.addr] = it.pixel;
			n_writes++;
		end else begin
			px = sample_pos(cur_step_x, it.out_x);
			py = sample_pos(cur_step_y, it.out_y);
			fx = px[FRAC-1:0];
			fy = py[FRAC-1:0];
			b = cell_addr(px, py);
			a01 = b + 17'd1;
			a10 = b + bfs_pkg::ADDR_IN_W'(cur_width);
			a11 = a10 + 17'd1;
			p00 = pixel_mem[b];
			p01 = pixel_mem[a01];
			p10 = pixel_mem[a10];
			p11 = pixel_mem[a11];
			c = p00;
			if (fx != 0 && fy != 0) begin
				for (k = 0; k < bfs_pkg::NUM_CHAN; k++)
					c[8*k +: 8] = mix4(p00[8*k +: 8], p01[8*k +: 8], p10[8*k +: 8],
						p11[8*k +: 8], fx, fy);
			end else if (fx != 0 || fy != 0) begin
				nb = (fy == 0) ? p01 : p10;
				for (k = 0; k < bfs_pkg::NUM_CHAN; k++)
					c[8*k +: 8] = mix2(p00[8*k +: 8], nb[8*k +: 8], (fy == 0) ? fx : fy);
			end
			expected_colors.push_back(c);
			n_reads++;
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready)
				apply_item(cur_req);
			if (!req_if.valid || req_if.ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					cur_req = pending_items.pop_front();
					req_if.valid <= 1'b1;
					req_if.op    <= cur_req.op;
					req_if.addr  <= cur_req.addr;
					req_if.pixel <= cur_req.pixel;
					req_if.out_x <= cur_req.out_x;
					req_if.out_y <= cur_req.out_y;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_colors.size() == 0) begin
					err_count++;
					$display("%0t: unexpected color %06h with none pending", $time,
						rsp_if.color);
				end else begin
					want_color = expected_colors.pop_front();
					n_checked++;
					if (rsp_if.color !== want_color) begin
						err_count++;
						$display("%0t: color mismatch, expected %06h, got %06h", $time,
							want_color, rsp_if.color);
					end
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// watchdog on cycles without any handshake
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	task automatic push_write(input logic [bfs_pkg::ADDR_IN_W-1:0] a,
			input logic [bfs_pkg::PIX_W-1:0] p);
		scaler_req_t it;
		it.op    = bfs_pkg::OP_WRITE;
		it.addr  = a;
		it.pixel = p;
		it.out_x = bfs_pkg::COORD_W'($urandom_range(2047));
		it.out_y = bfs_pkg::COORD_W'($urandom_range(2047));
		pending_items.push_back(it);
	endtask

	task automatic push_read(input logic [bfs_pkg::COORD_W-1:0] x,
			input logic [bfs_pkg::COORD_W-1:0] y);
		scaler_req_t it;
		it.op    = bfs_pkg::OP_READ;
		it.addr  = bfs_pkg::ADDR_IN_W'($urandom_range(17'h1FFFF));
		it.pixel = bfs_pkg::PIX_W'($urandom_range(24'hFFFFFF));
		it.out_x = x;
		it.out_y = y;
		pending_items.push_back(it);
	endtask

	// loads the neighbours of one sample point, then reads it
	task automatic push_probe(input logic [bfs_pkg::COORD_W-1:0] x,
			input logic [bfs_pkg::COORD_W-1:0] y,
			input logic [bfs_pkg::PIX_W-1:0] c00, input logic [bfs_pkg::PIX_W-1:0] c01,
			input logic [bfs_pkg::PIX_W-1:0] c10, input logic [bfs_pkg::PIX_W-1:0] c11);
		logic [bfs_pkg::ADDR_IN_W-1:0] b, bl;
		b = cell_addr(sample_pos(cur_step_x, x), sample_pos(cur_step_y, y));
		bl = b + bfs_pkg::ADDR_IN_W'(cur_width);
		push_write(b, c00);
		push_write(b + 17'd1, c01);
		push_write(bl, c10);
		push_write(bl + 17'd1, c11);
		push_read(x, y);
	endtask

	task automatic apb_access(input logic [1:0] idx, input logic wr,
			input logic [bfs_pkg::APB_DW-1:0] wdata,
			output logic [bfs_pkg::APB_DW-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [bfs_pkg::APB_DW-1:0] value);
		logic [bfs_pkg::APB_DW-1:0] unused;
		apb_access(idx, 1'b1, value, unused);
		case (idx)
			bfs_pkg::REG_SRC_WIDTH: cur_width  = value[bfs_pkg::WIDTH_W-1:0];
			bfs_pkg::REG_STEP_X:    cur_step_x = value[bfs_pkg::STEP_W-1:0];
			bfs_pkg::REG_STEP_Y:    cur_step_y = value[bfs_pkg::STEP_W-1:0];
			default:       ;
		endcase
	endtask

	task automatic check_reg(input logic [1:0] idx, input logic [bfs_pkg::APB_DW-1:0] want);
		logic [bfs_pkg::APB_DW-1:0] got;
		apb_access(idx, 1'b0, '0, got);
		if (got !== want) begin
			err_count++;
			$display("%0t: register %0d readback, expected %08h, got %08h", $time, idx,
				want, got);
		end
	endtask

	task automatic check_regs();
		check_reg(bfs_pkg::REG_SRC_WIDTH, bfs_pkg::APB_DW'(cur_width));
		check_reg(bfs_pkg::REG_STEP_X, bfs_pkg::APB_DW'(cur_step_x));
		check_reg(bfs_pkg::REG_STEP_Y, bfs_pkg::APB_DW'(cur_step_y));
	endtask

	// upper pwdata bits carry junk that the block must drop
	task automatic program_scale(input logic [bfs_pkg::WIDTH_W-1:0] w,
			input logic [bfs_pkg::STEP_W-1:0] sx, input logic [bfs_pkg::STEP_W-1:0] sy);
		set_reg(bfs_pkg::REG_SRC_WIDTH, {20'($urandom), w});
		set_reg(bfs_pkg::REG_STEP_X, {8'($urandom), sx});
		set_reg(bfs_pkg::REG_STEP_Y, {8'($urandom), sy});
		if ($urandom_range(1) == 0)
			set_reg(REG_UNUSED, $urandom);
		check_regs();
		n_settings++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || req_if.valid || expected_colors.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_pace(input int mode);
		case (mode)
			0: begin send_gap_pct = 0;  stall_pct = 0;  end
			1: begin send_gap_pct = 52; stall_pct = 0;  end
			2: begin send_gap_pct = 0;  stall_pct = 52; end
			default: begin send_gap_pct = 9; stall_pct = 9; end
		endcase
	endtask

	function automatic logic [bfs_pkg::STEP_W-1:0] pick_step();
		case ($urandom_range(7))
			0: return 24'h010000;
			1: return 24'h000000;
			2: return 24'hFFFFFF;
			3: return bfs_pkg::STEP_W'(24'h008000 * $urandom_range(1, 6));
			4: return bfs_pkg::STEP_W'($urandom_range(24'hFFFFFF));
			default: return bfs_pkg::STEP_W'($urandom_range(24'h3FFFF, 24'h100));
		endcase
	endfunction

	function automatic logic [bfs_pkg::WIDTH_W-1:0] pick_width();
		case ($urandom_range(5))
			0: return 12'd1;
			1: return 12'd4095;
			2: return 12'd2048;
			3: return 12'd0;
			default: return bfs_pkg::WIDTH_W'($urandom_range(64, 1));
		endcase
	endfunction

	function automatic logic [bfs_pkg::COORD_W-1:0] pick_coord();
		if ($urandom_range(3) == 0)
			return bfs_pkg::COORD_W'($urandom_range(2047));
		return bfs_pkg::COORD_W'($urandom_range(31));
	endfunction

	function automatic logic [bfs_pkg::PIX_W-1:0] rand_pixel();
		return bfs_pkg::PIX_W'($urandom_range(24'hFFFFFF));
	endfunction

	initial begin
		int phase, count;
		logic [bfs_pkg::COORD_W-1:0] x, y;
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.op     = '0;
		req_if.addr   = '0;
		req_if.pixel  = '0;
		req_if.out_x  = '0;
		req_if.out_y  = '0;
		rsp_if.ready  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset values, plain copies at unit step and the far corners of the store
		check_regs();
		set_pace(0);
		push_read(11'd5, 11'd5);
		push_write(17'd0, 24'hFFFFFF);
		push_write(17'h1FFFF, 24'h0F0F0F);
		push_write(17'd34415, 24'h00FF00);
		push_read(11'd0, 11'd0);
		push_read(11'd271, 11'd327);
		push_read(11'd2047, 11'd2047);
		wait_idle();

		// horizontal blend landing on an exact half
		program_scale(12'd4095, 24'h008000, 24'h010000);
		push_probe(11'd0, 11'd1, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000);
		wait_idle();

		// zero width folds the lower row onto the base row
		program_scale(12'd0, 24'h018000, 24'h004000);
		push_probe(11'd2047, 11'd2047, 24'h123456, 24'hFEDCBA, 24'h00FF80, 24'h7F7F7F);
		wait_idle();

		// zero horizontal step, largest vertical step
		program_scale(12'd2048, 24'h000000, 24'hFFFFFF);
		push_probe(11'd2047, 11'd0, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000);
		wait_idle();

		program_scale(12'd1, 24'hFFFFFF, 24'h000000);
		push_probe(11'd2047, 11'd2047, 24'h80FF01, 24'h01FF80, 24'hFF0000, 24'h0000FF);
		wait_idle();

		for (phase = 0; phase < 8; phase++) begin
			program_scale(pick_width(), pick_step(), pick_step());
			set_pace(phase % 4);
			count = 0;
			while (count < PHASE_ITEMS) begin
				case ($urandom_range(99) / 5)
					0, 1, 2: begin
						push_write(bfs_pkg::ADDR_IN_W'($urandom_range(17'h1FFFF)),
							rand_pixel());
						count++;
					end
					3, 4: begin
						push_read(bfs_pkg::COORD_W'($urandom_range(2047)),
							bfs_pkg::COORD_W'($urandom_range(2047)));
						count++;
					end
					default: begin
						x = pick_coord();
						y = pick_coord();
						push_probe(x, y, rand_pixel(), rand_pixel(), rand_pixel(),
							rand_pixel());
						count += 5;
					end
				endcase
			end
			wait_idle();
		end

		$display("covered %0d pixel writes and %0d output pixel reads over %0d scale settings",
			n_writes, n_reads, n_settings);
		$display("%0d interpolated colors checked, %0d errors", n_checked, err_count);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bfs_pkg.sv
hdl/bfs_in_if.sv
hdl/bfs_out_if.sv
hdl/bfs_cfg.sv
hdl/bfs_front.sv
hdl/bfs_cmd_queue.sv
hdl/bfs_back.sv
hdl/bilinear_frame_scaler.sv
tb/tb_top.sv
